@@ sv/owbm_pkg.sv @@
// Shared types and constants for the single-wire bus master.
package owbm_pkg;

  // Input mode codes as they arrive on the input channel.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_RESET = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW     = 3'd0;
  localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
  localparam logic [2:0] REG_WRITE_ONE_LOW = 3'd3;
  localparam logic [2:0] REG_WRITE_SLOT    = 3'd4;
  localparam logic [2:0] REG_READ_LOW      = 3'd5;
  localparam logic [2:0] REG_READ_RECOVER  = 3'd6;

  // Configuration reset values.
  localparam logic [15:0] RESET_LOW_DEFAULT     = 16'd480;
  localparam logic [15:0] PRESENCE_WAIT_DEFAULT = 16'd80;
  localparam logic [15:0] RESET_RECOVER_DEFAULT = 16'd400;
  localparam logic [7:0]  WRITE_ONE_LOW_DEFAULT = 8'd1;
  localparam logic [7:0]  WRITE_SLOT_DEFAULT    = 8'd50;
  localparam logic [7:0]  READ_LOW_DEFAULT      = 8'd2;
  localparam logic [7:0]  READ_RECOVER_DEFAULT  = 8'd60;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_TICK,
    OP_RESET,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       bus_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       bus_level;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic [15:0] reset_low_ticks;
    logic [15:0] presence_wait_ticks;
    logic [15:0] reset_recover_ticks;
    logic [7:0]  write_one_low_ticks;
    logic [7:0]  write_slot_ticks;
    logic [7:0]  read_low_ticks;
    logic [7:0]  read_recover_ticks;
  } cfg_t;

endpackage

@@ sv/owbm_front.sv @@
// Front end: accepts input items, decodes the mode and queues them for the back end.
module owbm_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  owbm_pkg::in_item_t  in_item,
  output owbm_pkg::queue_head_t head,
  input  logic                pop
);

  owbm_pkg::queue_entry_t entries [owbm_pkg::QUEUE_DEPTH];
  logic [owbm_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [owbm_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [owbm_pkg::QUEUE_CW-1:0] count;
  owbm_pkg::queue_entry_t        decoded;
  logic                          push;

  // Turn the raw mode field into an operation code.
  always_comb begin
    decoded.data_byte = in_item.data_byte;
    decoded.bus_level = in_item.bus_level;
    unique case (in_item.mode)
      owbm_pkg::MODE_TICK:  decoded.op = owbm_pkg::OP_TICK;
      owbm_pkg::MODE_RESET: decoded.op = owbm_pkg::OP_RESET;
      owbm_pkg::MODE_WRITE: decoded.op = owbm_pkg::OP_WRITE;
      owbm_pkg::MODE_READ:  decoded.op = owbm_pkg::OP_READ;
      default:              decoded.op = owbm_pkg::OP_TICK;
    endcase
  end

  assign in_stall = (count == owbm_pkg::QUEUE_CW'(owbm_pkg::QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;

  assign head.valid = (count != '0);
  assign head.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ sv/owbm_back.sv @@
// Back end: slot timing sequencer and the registered result stage.
module owbm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  owbm_pkg::cfg_t        cfg,
  input  owbm_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output owbm_pkg::out_item_t   out_item
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WAIT,
    PH_RST_REC,
    PH_W_LOW,
    PH_W_REL,
    PH_R_LOW,
    PH_R_SAMP,
    PH_R_REC
  } phase_t;

  // Length of a phase in ticks; write slots depend on the bit being sent.
  function automatic logic [15:0] phase_len(phase_t p, owbm_pkg::cfg_t c, logic b);
    logic [15:0] len;
    unique case (p)
      PH_RST_LOW:  len = c.reset_low_ticks;
      PH_RST_WAIT: len = c.presence_wait_ticks;
      PH_RST_REC:  len = c.reset_recover_ticks;
      PH_W_LOW:    len = b ? {8'd0, c.write_one_low_ticks} : {8'd0, c.write_slot_ticks};
      PH_W_REL:    len = b ? {8'd0, c.write_slot_ticks} : 16'd0;
      PH_R_LOW:    len = {8'd0, c.read_low_ticks};
      PH_R_SAMP:   len = 16'd1;
      PH_R_REC:    len = {8'd0, c.read_recover_ticks};
      default:     len = 16'd0;
    endcase
    return len;
  endfunction

  phase_t      phase;
  logic [15:0] tick_count;
  logic [2:0]  bit_index;
  logic [7:0]  shift_byte;
  logic        presence_flag;
  logic [7:0]  read_result;
  logic        chain;
  logic        chain_level;

  phase_t      phase_next;
  logic [15:0] tick_count_next;
  logic [2:0]  bit_index_next;
  logic [7:0]  shift_byte_next;
  logic        presence_flag_next;
  logic [7:0]  read_result_next;
  logic        chain_next;
  logic        level;
  logic        out_room;
  logic        do_end;
  logic        emit;
  logic        done;
  logic        rej;
  logic [15:0] count_inc;

  assign out_room  = !out_valid || !out_stall;
  assign pop       = out_room && !chain && head.valid;
  assign level     = chain ? chain_level : head.entry.bus_level;
  assign count_inc = tick_count + 16'd1;

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    presence_flag_next = presence_flag;
    read_result_next   = read_result;
    chain_next         = chain;
    do_end             = 1'b0;
    emit               = 1'b0;
    done               = 1'b0;
    rej                = 1'b0;

    if (chain && out_room) begin
      do_end = 1'b1;
    end else if (pop) begin
      if (head.entry.op == owbm_pkg::OP_TICK) begin
        if (phase != PH_IDLE) begin
          tick_count_next = count_inc;
          if (count_inc >= phase_len(phase, cfg, shift_byte[bit_index])) begin
            do_end = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end else begin
          emit = 1'b1;
        end
      end else if (phase != PH_IDLE) begin
        rej  = 1'b1;
        emit = 1'b1;
      end else begin
        tick_count_next = '0;
        bit_index_next  = '0;
        emit            = 1'b1;
        case (head.entry.op)
          owbm_pkg::OP_RESET: phase_next = PH_RST_LOW;
          owbm_pkg::OP_WRITE: begin
            phase_next      = PH_W_LOW;
            shift_byte_next = head.entry.data_byte;
          end
          default: begin
            phase_next      = PH_R_LOW;
            shift_byte_next = '0;
          end
        endcase
      end
    end

    // Leave the current phase. A following phase of zero length is passed in
    // further cycles of the same item, using the level that item carried.
    if (do_end) begin
      tick_count_next = '0;
      phase_next      = PH_IDLE;
      unique case (phase)
        PH_RST_LOW:  phase_next = PH_RST_WAIT;
        PH_RST_WAIT: begin
          presence_flag_next = !level;
          phase_next         = PH_RST_REC;
        end
        PH_RST_REC:  done = 1'b1;
        PH_W_LOW:    phase_next = PH_W_REL;
        PH_W_REL: begin
          if (bit_index == 3'd7) begin
            done = 1'b1;
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_W_LOW;
          end
        end
        PH_R_LOW:    phase_next = PH_R_SAMP;
        PH_R_SAMP: begin
          shift_byte_next = {level, shift_byte[7:1]};
          phase_next      = PH_R_REC;
        end
        PH_R_REC: begin
          if (bit_index == 3'd7) begin
            read_result_next = shift_byte;
            done             = 1'b1;
          end else begin
            bit_index_next = bit_index + 3'd1;
            phase_next     = PH_R_LOW;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
      if (done || phase_len(phase_next, cfg, shift_byte_next[bit_index_next]) != 16'd0) begin
        emit       = 1'b1;
        chain_next = 1'b0;
      end else begin
        chain_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      read_result   <= '0;
      chain         <= 1'b0;
      chain_level   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      read_result   <= read_result_next;
      chain         <= chain_next;
      if (pop) begin
        chain_level <= head.entry.bus_level;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item.drive_low <= (phase_next == PH_RST_LOW) || (phase_next == PH_W_LOW) ||
                            (phase_next == PH_R_LOW);
      out_item.busy_res  <= (phase_next != PH_IDLE);
      out_item.done_res  <= done;
      out_item.presence  <= presence_flag_next;
      out_item.read_byte <= read_result_next;
      out_item.rejected  <= rej;
    end
  end

  // A pending zero-length phase always belongs to a command in progress.
  a_chain_busy: assert property (@(posedge clk) disable iff (rst)
    chain |-> (phase != PH_IDLE))
    else $error("chained phase step while idle");

  // Every chained step moves to another phase or another bit.
  a_chain_progress: assert property (@(posedge clk) disable iff (rst)
    (chain && out_room) |=> (phase != $past(phase)) || (bit_index != $past(bit_index)))
    else $error("chained phase step made no progress");

  // A rejected command leaves the running command untouched.
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.rejected) |-> out_item.busy_res)
    else $error("rejected command reported while idle");

  // Completion returns the sequencer to idle with the line released.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.done_res) |-> (!out_item.busy_res && !out_item.drive_low))
    else $error("completion reported while still busy");

endmodule

@@ sv/one_wire_bus_master_core.sv @@
// Top level of the single-wire bus master: configuration registers, front end and back end.
//
//  Channel   Signals                          Direction  Carries
//  input     in_valid, in_stall, in_item      in         tick or command item
//  result    out_valid, out_stall, out_item   out        one result item per input item
//  config    cfg_write_en, cfg_index, cfg_data in        timing register writes
//
// An item that ends at most one phase frees the back end at once, so the block sustains
// one item per cycle unless out_stall holds the result. A tick that ends a phase and runs
// into zero-length phases holds the back end while it passes them (with all slot lengths
// at zero, one tick runs every phase of a whole byte write); the four-entry command queue
// keeps taking items meanwhile until full. Results pass through one output register,
// so an item can be accepted while the previous result still waits under out_stall.
// Reset is synchronous: it empties the queue and the output register, returns the
// sequencer to idle and loads the timing registers with their default values.
module one_wire_bus_master_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  owbm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output owbm_pkg::out_item_t out_item,
  input  logic                cfg_write_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  owbm_pkg::cfg_t        cfg;
  owbm_pkg::queue_head_t head;
  logic                  pop;

  // Timing registers. Writes to an index beyond the list are dropped, and the
  // eight-bit registers keep the low byte of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_ticks     <= owbm_pkg::RESET_LOW_DEFAULT;
      cfg.presence_wait_ticks <= owbm_pkg::PRESENCE_WAIT_DEFAULT;
      cfg.reset_recover_ticks <= owbm_pkg::RESET_RECOVER_DEFAULT;
      cfg.write_one_low_ticks <= owbm_pkg::WRITE_ONE_LOW_DEFAULT;
      cfg.write_slot_ticks    <= owbm_pkg::WRITE_SLOT_DEFAULT;
      cfg.read_low_ticks      <= owbm_pkg::READ_LOW_DEFAULT;
      cfg.read_recover_ticks  <= owbm_pkg::READ_RECOVER_DEFAULT;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        owbm_pkg::REG_RESET_LOW:     cfg.reset_low_ticks     <= cfg_data;
        owbm_pkg::REG_PRESENCE_WAIT: cfg.presence_wait_ticks <= cfg_data;
        owbm_pkg::REG_RESET_RECOVER: cfg.reset_recover_ticks <= cfg_data;
        owbm_pkg::REG_WRITE_ONE_LOW: cfg.write_one_low_ticks <= cfg_data[7:0];
        owbm_pkg::REG_WRITE_SLOT:    cfg.write_slot_ticks    <= cfg_data[7:0];
        owbm_pkg::REG_READ_LOW:      cfg.read_low_ticks      <= cfg_data[7:0];
        owbm_pkg::REG_READ_RECOVER:  cfg.read_recover_ticks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // The front end takes items and queues them in arrival order.
  owbm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .head     (head),
    .pop      (pop)
  );

  // The back end runs the slot timing and holds the result register.
  owbm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
